>>> src/overwrite_ring_buffer_with_peek_macros.svh
// Assertion macros shared by the sample ring buffer modules.
`ifndef OVERWRITE_RING_BUFFER_WITH_PEEK_MACROS_SVH
`define OVERWRITE_RING_BUFFER_WITH_PEEK_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ORBP_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("ring buffer check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ORBP_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("ring buffer check failed");
`else
`define ORBP_ASSERT_IMPL(lbl, ant, cons)
`define ORBP_ASSERT_NEXT(lbl, ant, cons)
`endif

`endif

>>> src/orbp_pkg.sv
// Types and constants shared by the sample ring buffer modules.
`default_nettype none

package orbp_pkg;

  localparam int DATA_W = 32;
  localparam int KIND_W = 2;
  localparam int CNT_W  = 7;
  localparam int LVL_W  = 10;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_PEEK  = 2'd2,
    KIND_LEVEL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_RUN   = 2'd2
  } back_state_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    kind_t             kind;
    logic [CNT_W-1:0]  count;
    logic [LVL_W-1:0]  lvl;
  } cmd_info_t;

  // Side information traveling with one RAM read.
  typedef struct packed {
    logic              use_ram;
    logic              is_last;
    logic              empty_run;
    logic [CNT_W-1:0]  run_length;
    logic [LVL_W-1:0]  fill_level;
  } res_meta_t;

  // One result word.
  typedef struct packed {
    logic [DATA_W-1:0] data_word;
    logic              is_last;
    logic              empty_run;
    logic [CNT_W-1:0]  run_length;
    logic [LVL_W-1:0]  fill_level;
  } res_t;

endpackage

`default_nettype wire

>>> src/orbp_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module orbp_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/orbp_fifo.sv
// Small register FIFO with occupancy count.
`default_nettype none

module orbp_fifo #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr,
  input  wire logic [W-1:0]           wdata,
  input  wire logic                   rd,
  output logic      [W-1:0]           rdata,
  output logic                        full,
  output logic                        empty,
  output logic      [$clog2(N+1)-1:0] count
);

  localparam int PW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = $clog2(N + 1);

  logic [W-1:0]  mem_r [N];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == CW'(N));
  assign empty = (cnt_r == '0);
  assign count = cnt_r;
  assign rdata = mem_r[rd_ptr_r];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(N - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(N - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> src/orbp_front.sv
// Front end: accept words, track pointers, classify into commands.
`default_nettype none

`include "overwrite_ring_buffer_with_peek_macros.svh"

module orbp_front #(
  parameter int DEPTH   = 1024,
  parameter int MAX_RUN = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [orbp_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [orbp_pkg::DATA_W-1:0]   in_sample_word,
  input  wire logic [orbp_pkg::CNT_W-1:0]    in_request_count,
  input  wire logic                          q_full,
  input  wire logic                          clearing,
  output logic                               cmd_wr,
  output orbp_pkg::cmd_info_t                cmd_info,
  output logic      [$clog2(DEPTH)-1:0]      cmd_addr,
  output logic      [orbp_pkg::DATA_W-1:0]   cmd_word
);

  localparam int PW = $clog2(DEPTH);
  localparam int XW = ((PW > orbp_pkg::CNT_W) ? PW : orbp_pkg::CNT_W) + 1;

  logic [PW-1:0]              wp_r, wp_nxt;
  logic [PW-1:0]              rp_r, rp_nxt;
  logic                       accept;
  orbp_pkg::kind_t            kind;
  logic [orbp_pkg::CNT_W-1:0] req_sat;
  logic [XW-1:0]              wp_x, rp_x, depth_x, lvl_x, req_x, n_x, start_x, rp_sum_x;

  assign full     = q_full || clearing;
  assign accept   = push && !full;
  assign kind     = orbp_pkg::kind_t'(in_kind);
  assign cmd_wr   = accept;
  assign cmd_word = in_sample_word;

  assign wp_x    = XW'(wp_r);
  assign rp_x    = XW'(rp_r);
  assign depth_x = XW'(DEPTH);
  assign req_sat = (in_request_count > orbp_pkg::CNT_W'(MAX_RUN)) ?
                   orbp_pkg::CNT_W'(MAX_RUN) : in_request_count;
  assign req_x   = XW'(req_sat);
  assign lvl_x   = (wp_r >= rp_r) ? (wp_x - rp_x) : (wp_x + depth_x - rp_x);

  always_comb begin
    n_x           = '0;
    cmd_addr      = wp_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    start_x       = '0;
    rp_sum_x      = '0;
    cmd_info.kind = kind;
    cmd_info.lvl  = orbp_pkg::LVL_W'(lvl_x);
    unique case (kind)
      orbp_pkg::KIND_PUSH: begin
        cmd_addr = wp_r;
        wp_nxt   = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      orbp_pkg::KIND_READ: begin
        n_x      = (req_x > lvl_x) ? lvl_x : req_x;
        cmd_addr = rp_r;
        rp_sum_x = rp_x + n_x;
        rp_nxt   = PW'((rp_sum_x >= depth_x) ? (rp_sum_x - depth_x) : rp_sum_x);
      end
      orbp_pkg::KIND_PEEK: begin
        n_x      = (req_x > depth_x - XW'(1)) ? (depth_x - XW'(1)) : req_x;
        start_x  = (wp_x >= n_x) ? (wp_x - n_x) : (wp_x + depth_x - n_x);
        cmd_addr = PW'(start_x);
      end
      orbp_pkg::KIND_LEVEL: begin
        n_x = '0;
      end
      default: begin
        n_x = '0;
      end
    endcase
    cmd_info.count = orbp_pkg::CNT_W'(n_x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else if (accept) begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  `ORBP_ASSERT_IMPL(a_ptr_range, 1'b1, (wp_x < depth_x) && (rp_x < depth_x))
  `ORBP_ASSERT_NEXT(a_rp_hold, !(accept && kind == orbp_pkg::KIND_READ), $stable(rp_r))

endmodule

`default_nettype wire

>>> src/orbp_back.sv
// Back end: clear the store, write pushes, send single words, sequence run reads.
`default_nettype none

`include "overwrite_ring_buffer_with_peek_macros.svh"

module orbp_back #(
  parameter int DEPTH = 1024,
  parameter int OQ_N  = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_valid,
  input  wire orbp_pkg::cmd_info_t           cmd_info,
  input  wire logic [$clog2(DEPTH)-1:0]      cmd_addr,
  input  wire logic [orbp_pkg::DATA_W-1:0]   cmd_word,
  output logic                               cmd_pop,
  output logic                               clearing,
  output logic                               ram_we,
  output logic      [$clog2(DEPTH)-1:0]      ram_waddr,
  output logic      [orbp_pkg::DATA_W-1:0]   ram_wdata,
  output logic      [$clog2(DEPTH)-1:0]      ram_raddr,
  input  wire logic [orbp_pkg::DATA_W-1:0]   ram_rdata,
  input  wire logic [$clog2(OQ_N+1)-1:0]     oq_count,
  output logic                               res_wr,
  output orbp_pkg::res_t                     res
);

  localparam int PW = $clog2(DEPTH);
  localparam int QW = $clog2(OQ_N + 1) + 1;

  orbp_pkg::back_state_t      state_r, state_nxt;
  logic [PW-1:0]              clr_addr_r, clr_addr_nxt;
  logic [PW-1:0]              addr_r, addr_nxt;
  logic [orbp_pkg::CNT_W-1:0] remain_r, remain_nxt;
  orbp_pkg::cmd_info_t        info_r, info_nxt;
  logic                       issue_r, issue_nxt;
  orbp_pkg::res_meta_t        meta_r, meta_nxt;
  logic                       credit_ok;

  // Count the word already in flight from the RAM against the queue space.
  assign credit_ok = (QW'(oq_count) + QW'(issue_r)) < QW'(OQ_N);
  assign clearing  = (state_r == orbp_pkg::BK_CLEAR);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    addr_nxt     = addr_r;
    remain_nxt   = remain_r;
    info_nxt     = info_r;
    issue_nxt    = 1'b0;
    meta_nxt     = meta_r;
    cmd_pop      = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = cmd_addr;
    ram_wdata    = cmd_word;
    ram_raddr    = addr_r;
    unique case (state_r)
      orbp_pkg::BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == PW'(DEPTH - 1)) begin
          state_nxt = orbp_pkg::BK_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      orbp_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd_info.kind == orbp_pkg::KIND_PUSH) begin
            ram_we  = 1'b1;
            cmd_pop = 1'b1;
          end else if (cmd_info.count == '0) begin
            // Level report or empty run: one word, no store access.
            if (credit_ok) begin
              cmd_pop             = 1'b1;
              issue_nxt           = 1'b1;
              meta_nxt.use_ram    = 1'b0;
              meta_nxt.is_last    = 1'b1;
              meta_nxt.empty_run  = (cmd_info.kind != orbp_pkg::KIND_LEVEL);
              meta_nxt.run_length = '0;
              meta_nxt.fill_level = cmd_info.lvl;
            end
          end else begin
            cmd_pop    = 1'b1;
            addr_nxt   = cmd_addr;
            remain_nxt = cmd_info.count;
            info_nxt   = cmd_info;
            state_nxt  = orbp_pkg::BK_RUN;
          end
        end
      end
      orbp_pkg::BK_RUN: begin
        if (credit_ok) begin
          issue_nxt           = 1'b1;
          meta_nxt.use_ram    = 1'b1;
          meta_nxt.is_last    = (remain_r == orbp_pkg::CNT_W'(1));
          meta_nxt.empty_run  = 1'b0;
          meta_nxt.run_length = info_r.count;
          meta_nxt.fill_level = info_r.lvl;
          addr_nxt            = (addr_r == PW'(DEPTH - 1)) ? '0 : addr_r + 1'b1;
          remain_nxt          = remain_r - 1'b1;
          if (remain_r == orbp_pkg::CNT_W'(1)) begin
            state_nxt = orbp_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = orbp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= orbp_pkg::BK_CLEAR;
      clr_addr_r <= '0;
      issue_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      issue_r    <= issue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    remain_r <= remain_nxt;
    info_r   <= info_nxt;
    meta_r   <= meta_nxt;
  end

  assign res_wr         = issue_r;
  assign res.data_word  = meta_r.use_ram ? ram_rdata : '0;
  assign res.is_last    = meta_r.is_last;
  assign res.empty_run  = meta_r.empty_run;
  assign res.run_length = meta_r.run_length;
  assign res.fill_level = meta_r.fill_level;

  `ORBP_ASSERT_IMPL(a_credit, issue_r, oq_count < ($clog2(OQ_N+1))'(OQ_N))
  `ORBP_ASSERT_IMPL(a_run_remain, state_r == orbp_pkg::BK_RUN, remain_r != '0)

endmodule

`default_nettype wire

>>> src/overwrite_ring_buffer_with_peek.sv
// Top level of the overwriting sample ring buffer with peek.
`default_nettype none

// Overwriting sample ring buffer. Each accepted word is one of four kinds:
// push stores a 32-bit sample and produces no result; read returns up to
// request_count samples (capped at MAX_RUN and at the fill level) from the
// read pointer and consumes them; peek returns the newest request_count
// samples (capped at MAX_RUN and DEPTH-1) ending just before the write
// pointer, oldest first, without consuming; level returns one word carrying
// the fill level. A read or peek that ends up with zero samples returns one
// word flagged empty_run. Every run flags its final word with is_last, and
// fill_level is (write - read) mod DEPTH taken before the word acts, low ten
// bits. The writer never stops at the reader: an overrun wraps the level and
// stale data is returned as stored.
// Timing: after reset the block sweeps the sample store to zero, one entry
// per cycle, and holds full high until the sweep ends. After that the front
// accepts one word per cycle, while full is low, into a two-entry command
// queue; the back, which owns the single write port and single read port of
// the store, writes a push straight away, issues a level or empty word with
// no store access, and handles a run of n samples with a load step, then one
// store read per cycle while the result queue has room. A result word passes
// through the registered store read and is then written into the four-entry
// result queue, and the back issues only while that queue has room for the
// word. A stalled reader therefore stalls the back first, then fills the
// command queue, and finally raises full.
module overwrite_ring_buffer_with_peek #(
  parameter int DEPTH   = 1024,
  parameter int MAX_RUN = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input word channel
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [orbp_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [orbp_pkg::DATA_W-1:0]   in_sample_word,
  input  wire logic [orbp_pkg::CNT_W-1:0]    in_request_count,
  // result word channel
  output logic                               empty,
  input  wire logic                          pop,
  output logic      [orbp_pkg::DATA_W-1:0]   out_data_word,
  output logic                               out_is_last,
  output logic                               out_empty_run,
  output logic      [orbp_pkg::CNT_W-1:0]    out_run_length,
  output logic      [orbp_pkg::LVL_W-1:0]    out_fill_level
);

  localparam int PW     = $clog2(DEPTH);
  localparam int CMDQ_N = 2;
  localparam int OQ_N   = 4;
  localparam int CMD_W  = $bits(orbp_pkg::cmd_info_t) + PW + orbp_pkg::DATA_W;
  localparam int RES_W  = $bits(orbp_pkg::res_t);

  // front to command queue
  logic                        cmd_wr;
  orbp_pkg::cmd_info_t         fr_info;
  logic [PW-1:0]               fr_addr;
  logic [orbp_pkg::DATA_W-1:0] fr_word;
  logic                        cmdq_full;
  logic                        cmdq_empty;
  logic [CMD_W-1:0]            cmdq_rdata;
  logic [$clog2(CMDQ_N+1)-1:0] cmdq_count;

  // command queue to back
  orbp_pkg::cmd_info_t         bk_info;
  logic [PW-1:0]               bk_addr;
  logic [orbp_pkg::DATA_W-1:0] bk_word;
  logic                        cmd_pop;
  logic                        clearing;

  // store ports
  logic                        ram_we;
  logic [PW-1:0]               ram_waddr;
  logic [orbp_pkg::DATA_W-1:0] ram_wdata;
  logic [PW-1:0]               ram_raddr;
  logic [orbp_pkg::DATA_W-1:0] ram_rdata;

  // back to result queue
  logic                        res_wr;
  orbp_pkg::res_t              res_in;
  orbp_pkg::res_t              res_out;
  logic [RES_W-1:0]            oq_rdata;
  logic                        oq_full;
  logic [$clog2(OQ_N+1)-1:0]   oq_count;

  orbp_front #(
    .DEPTH   (DEPTH),
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_kind          (in_kind),
    .in_sample_word   (in_sample_word),
    .in_request_count (in_request_count),
    .q_full           (cmdq_full),
    .clearing         (clearing),
    .cmd_wr           (cmd_wr),
    .cmd_info         (fr_info),
    .cmd_addr         (fr_addr),
    .cmd_word         (fr_word)
  );

  // Hold classified commands between front and back.
  orbp_fifo #(
    .W (CMD_W),
    .N (CMDQ_N)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (cmd_wr),
    .wdata ({fr_info, fr_addr, fr_word}),
    .rd    (cmd_pop),
    .rdata (cmdq_rdata),
    .full  (cmdq_full),
    .empty (cmdq_empty),
    .count (cmdq_count)
  );

  assign bk_word = cmdq_rdata[orbp_pkg::DATA_W-1:0];
  assign bk_addr = cmdq_rdata[orbp_pkg::DATA_W +: PW];
  assign bk_info = orbp_pkg::cmd_info_t'(cmdq_rdata[CMD_W-1 -: $bits(orbp_pkg::cmd_info_t)]);

  orbp_back #(
    .DEPTH (DEPTH),
    .OQ_N  (OQ_N)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmdq_empty),
    .cmd_info  (bk_info),
    .cmd_addr  (bk_addr),
    .cmd_word  (bk_word),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .oq_count  (oq_count),
    .res_wr    (res_wr),
    .res       (res_in)
  );

  // Sample store.
  orbp_ram #(
    .W (orbp_pkg::DATA_W),
    .D (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result queue; the back never writes it without a free entry.
  orbp_fifo #(
    .W (RES_W),
    .N (OQ_N)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (res_wr),
    .wdata (res_in),
    .rd    (pop),
    .rdata (oq_rdata),
    .full  (oq_full),
    .empty (empty),
    .count (oq_count)
  );

  assign res_out        = orbp_pkg::res_t'(oq_rdata);
  assign out_data_word  = res_out.data_word;
  assign out_is_last    = res_out.is_last;
  assign out_empty_run  = res_out.empty_run;
  assign out_run_length = res_out.run_length;
  assign out_fill_level = res_out.fill_level;

  `include "overwrite_ring_buffer_with_peek_macros.svh"

  // Command queue never holds more than its depth, result queue never sees a write when full.
  `ORBP_ASSERT_IMPL(a_cmdq_bound, 1'b1, cmdq_count <= ($clog2(CMDQ_N+1))'(CMDQ_N))
  `ORBP_ASSERT_IMPL(a_oq_no_drop, res_wr, !oq_full)

endmodule

`default_nettype wire
